@@ hdl/clcg_pkg.sv @@
// Package for the combined LCG draw block: Schrage constants, reciprocals
// and the sequencer state type. No dependencies.
`default_nettype none

package clcg_pkg;

    // Shift used with the fixed-point reciprocals of the Schrage quotients
    localparam int unsigned RecipShift = 47;
    // Width of the Schrage quotient and remainder (both stay below 2^16)
    localparam int unsigned QW = 16;

    // First generator: multiplier 40014, modulus 2147483563
    localparam logic [31:0] G1_QUOT  = 32'd53668;
    localparam logic [31:0] G1_MULT  = 32'd40014;
    localparam logic [31:0] G1_REST  = 32'd12211;
    localparam logic [32:0] G1_MOD   = 33'd2147483563;
    localparam logic [31:0] G1_RECIP = 32'((64'd1 << RecipShift) / 64'd53668);

    // Second generator: multiplier 40692, modulus 2147483399
    localparam logic [31:0] G2_QUOT  = 32'd52774;
    localparam logic [31:0] G2_MULT  = 32'd40692;
    localparam logic [31:0] G2_REST  = 32'd3791;
    localparam logic [32:0] G2_MOD   = 33'd2147483399;
    localparam logic [31:0] G2_RECIP = 32'((64'd1 << RecipShift) / 64'd52774);

    // Added to the combined draw when it is not positive
    localparam logic [32:0] WRAP_ADD  = 33'd2147483562;
    localparam logic [30:0] VALUE_MAX = 31'd2147483562;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECIP,
        ST_QMUL,
        ST_REM,
        ST_AR,
        ST_RQ,
        ST_FIN,
        ST_DRAW
    } t_state;

endpackage

`default_nettype wire

@@ hdl/clcg_req_if.sv @@
// Request channel of the combined LCG draw block: reseed flag and two seeds.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface clcg_req_if;
    logic               valid;
    logic               ready;
    logic               reseed;
    logic signed [31:0] seed_first;
    logic signed [31:0] seed_second;

    modport source (output valid, output reseed, output seed_first,
                    output seed_second, input ready);
    modport sink   (input valid, input reseed, input seed_first,
                    input seed_second, output ready);
endinterface

`default_nettype wire

@@ hdl/clcg_rsp_if.sv @@
// Response channel of the combined LCG draw block: one 31-bit draw.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface clcg_rsp_if;
    logic        valid;
    logic        ready;
    logic [30:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

@@ hdl/clcg_mul.sv @@
// Shared 32x32 unsigned multiplier with a registered product.
// Used by the draw sequencer for every product; no dependencies.
`default_nettype none

module clcg_mul (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic [63:0]      o_prod
);

    logic [63:0] r_prod;

    // Register the product for the next sequencer step
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ hdl/combined_lcg_uniform.sv @@
// Combined LCG draw block: two Schrage multiply-modulo steps, then z = s1 - s2.
// One request at a time: a new request is taken only in the idle step, after the
// combine step, which waits while o_rsp holds an unaccepted draw. One shared 32x32
// multiplier: four products per generator, six steps each, one to combine, one idle.
// Reset (synchronous, active low): both generator states clear to zero, no draw pending.
// Depends on clcg_pkg, clcg_req_if, clcg_rsp_if and clcg_mul.
`default_nettype none

module combined_lcg_uniform (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    clcg_req_if.sink   i_req,
    clcg_rsp_if.source o_rsp
);

    import clcg_pkg::*;

    t_state             r_state, n_state;
    logic               r_gen, n_gen;
    logic signed [31:0] r_first, r_second;
    logic [QW-1:0]      r_q, r_r;
    logic [31:0]        r_acc;
    logic               r_out_valid;
    logic [30:0]        r_value;

    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_prod;

    logic signed [31:0] cur_s;
    logic               s_neg;
    logic [31:0]        s_mag;
    logic [31:0]        k_quot, k_mult, k_rest, k_recip;
    logic [32:0]        k_mod;
    logic [31:0]        rem_raw;
    logic [QW-1:0]      q_fix, r_fix;
    logic signed [32:0] diff, n_val, n_wrap;
    logic signed [32:0] z_raw, z_wrap;
    logic               req_take;
    logic               draw_load;

    // Shared multiplier
    clcg_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    // Select the generator under work and its constants
    always_comb begin
        cur_s   = r_gen ? r_second : r_first;
        s_neg   = cur_s[31];
        s_mag   = s_neg ? (~cur_s + 32'd1) : cur_s;
        k_quot  = r_gen ? G2_QUOT  : G1_QUOT;
        k_mult  = r_gen ? G2_MULT  : G1_MULT;
        k_rest  = r_gen ? G2_REST  : G1_REST;
        k_recip = r_gen ? G2_RECIP : G1_RECIP;
        k_mod   = r_gen ? G2_MOD   : G1_MOD;
    end

    // Fix the reciprocal quotient, which may be one short
    always_comb begin
        rem_raw = s_mag - mul_prod[31:0];
        if (rem_raw >= k_quot) begin
            q_fix = r_q + QW'(1);
            r_fix = QW'(rem_raw - k_quot);
        end else begin
            q_fix = r_q;
            r_fix = rem_raw[QW-1:0];
        end
    end

    // Finish the step: a*r - rest*q on magnitudes, restore sign, add modulus if negative
    always_comb begin
        diff   = $signed({1'b0, r_acc}) - $signed({1'b0, mul_prod[31:0]});
        n_val  = s_neg ? -diff : diff;
        n_wrap = n_val[32] ? (n_val + $signed(k_mod)) : n_val;
    end

    // Combine both states into the draw
    always_comb begin
        z_raw  = $signed({1'b0, r_first}) - $signed({1'b0, r_second});
        z_wrap = (z_raw < 33'sd1) ? (z_raw + $signed(WRAP_ADD)) : z_raw;
    end

    assign req_take  = i_req.valid && i_req.ready;
    assign draw_load = (r_state == ST_DRAW) && (!r_out_valid || o_rsp.ready);

    // Hold the sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and multiplier operands
    always_comb begin
        n_state = r_state;
        n_gen   = r_gen;
        mul_a   = '0;
        mul_b   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = ST_RECIP;
                    n_gen   = 1'b0;
                end
            end
            ST_RECIP: begin
                mul_a   = s_mag;
                mul_b   = k_recip;
                n_state = ST_QMUL;
            end
            ST_QMUL: begin
                mul_a   = 32'(mul_prod[RecipShift +: QW]);
                mul_b   = k_quot;
                n_state = ST_REM;
            end
            ST_REM: begin
                n_state = ST_AR;
            end
            ST_AR: begin
                mul_a   = 32'(r_r);
                mul_b   = k_mult;
                n_state = ST_RQ;
            end
            ST_RQ: begin
                mul_a   = 32'(r_q);
                mul_b   = k_rest;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (r_gen) begin
                    n_state = ST_DRAW;
                end else begin
                    n_state = ST_RECIP;
                    n_gen   = 1'b1;
                end
            end
            ST_DRAW: begin
                if (draw_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Generator states, generator select and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen       <= 1'b0;
            r_first     <= '0;
            r_second    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_gen <= n_gen;
            if (req_take && i_req.reseed) begin
                r_first  <= i_req.seed_first;
                r_second <= i_req.seed_second;
            end
            if (r_state == ST_FIN) begin
                if (r_gen) begin
                    r_second <= n_wrap[31:0];
                end else begin
                    r_first <= n_wrap[31:0];
                end
            end
            if (draw_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the step and the output value
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_QMUL: begin
                r_q <= mul_prod[RecipShift +: QW];
            end
            ST_REM: begin
                r_q <= q_fix;
                r_r <= r_fix;
            end
            ST_RQ: begin
                r_acc <= mul_prod[31:0];
            end
            default: begin
            end
        endcase
        if (draw_load) begin
            r_value <= z_wrap[30:0];
        end
    end

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.value = r_value;

`ifndef SYNTHESIS
    // An accepted request starts on the first generator
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take |=> (r_state == ST_RECIP) && !r_gen)
        else $error("request did not start on the first generator");

    // A stepped first state lies in 0..modulus-1
    a_first_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) && !r_gen |=> !r_first[31] && ({1'b0, r_first} < G1_MOD))
        else $error("first state out of range after step");

    // A stepped second state lies in 0..modulus-1
    a_second_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) && r_gen |=> !r_second[31] && ({1'b0, r_second} < G2_MOD))
        else $error("second state out of range after step");

    // A presented draw is in 1..2147483562
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.value != 31'd0) && (o_rsp.value <= VALUE_MAX))
        else $error("draw out of range");

    // A new draw appears only out of the combine step
    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DRAW))
        else $error("draw presented outside the combine step");
`endif

endmodule

`default_nettype wire
